FILE: rtl/lfu_open_handle_cache_top_defines.svh
// Assertion macros shared by the handle cache RTL.
`ifndef LFU_OPEN_HANDLE_CACHE_TOP_DEFINES_SVH
`define LFU_OPEN_HANDLE_CACHE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LFU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LFU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lfu_ohc_pkg.sv
// Shared constants and types for the handle cache.
package lfu_ohc_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int COUNT_W = 32;
    localparam int CAP_W   = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic match;
        logic better;
    } t_cmp_res;

endpackage

FILE: rtl/lfu_ohc_mem.sv
// Entry store holding key and use count, one write and one registered read port.
module lfu_ohc_mem (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [lfu_ohc_pkg::IDX_W-1:0] i_waddr,
    input  lfu_ohc_pkg::t_entry           i_wdata,
    input  logic [lfu_ohc_pkg::IDX_W-1:0] i_raddr,
    output lfu_ohc_pkg::t_entry           o_rdata
);

    lfu_ohc_pkg::t_entry r_mem [lfu_ohc_pkg::ENTRIES];
    lfu_ohc_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/lfu_ohc_cmp.sv
// Shared compare unit: key match and least-frequently-used ordering of one entry.
module lfu_ohc_cmp (
    input  lfu_ohc_pkg::t_entry            i_entry,
    input  lfu_ohc_pkg::t_entry            i_best,
    input  logic [lfu_ohc_pkg::KEY_W-1:0]  i_key,
    output lfu_ohc_pkg::t_cmp_res          o_res
);

    always_comb begin
        o_res.match  = (i_entry.key == i_key);
        o_res.better = (i_entry.count < i_best.count) ||
                       ((i_entry.count == i_best.count) && (i_entry.key < i_best.key));
    end

endmodule

FILE: rtl/lfu_open_handle_cache_top.sv
// Top level of the least-frequently-used open-handle cache.
// An item with caching enabled is scanned one entry per cycle. A new item is
// taken only once the previous one has finished, as the input is ready only in idle.
// A bypassed item skips the scan and goes straight to the final step.
// A result still waiting in the output register holds the final step back.
// Synchronous active-low reset clears all valid bits and the capacity register.
`include "lfu_open_handle_cache_top_defines.svh"

module lfu_open_handle_cache_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lfu_ohc_pkg::CAP_W-1:0]       i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [lfu_ohc_pkg::KEY_W-1:0]       i_key,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_bypass,
    output logic                                o_hit,
    output logic                                o_evicted,
    output logic [lfu_ohc_pkg::KEY_W-1:0]       o_evicted_key,
    output logic [lfu_ohc_pkg::COUNT_W-1:0]     o_use_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    t_state                              r_state;
    logic [lfu_ohc_pkg::CAP_W-1:0]       r_max_open;
    logic [lfu_ohc_pkg::ENTRIES-1:0]     r_valid_bits;
    logic [lfu_ohc_pkg::KEY_W-1:0]       r_key;
    logic                                r_bypass;
    logic [lfu_ohc_pkg::CNT_W-1:0]       r_idx;
    logic                                r_pvld;
    logic [lfu_ohc_pkg::IDX_W-1:0]       r_pidx;
    logic [lfu_ohc_pkg::CNT_W-1:0]       r_used;
    logic                                r_found;
    logic [lfu_ohc_pkg::IDX_W-1:0]       r_found_idx;
    logic [lfu_ohc_pkg::COUNT_W-1:0]     r_found_cnt;
    logic                                r_have_best;
    lfu_ohc_pkg::t_entry                 r_best;
    logic [lfu_ohc_pkg::IDX_W-1:0]       r_best_idx;
    logic                                r_out_valid;
    logic                                r_out_bypass;
    logic                                r_out_hit;
    logic                                r_out_evicted;
    logic [lfu_ohc_pkg::KEY_W-1:0]       r_out_evicted_key;
    logic [lfu_ohc_pkg::COUNT_W-1:0]     r_out_use_count;

    lfu_ohc_pkg::t_entry                 rd_entry;
    lfu_ohc_pkg::t_entry                 wr_entry;
    lfu_ohc_pkg::t_cmp_res               cmp_res;
    logic                                mem_we;
    logic [lfu_ohc_pkg::IDX_W-1:0]       mem_waddr;
    logic                                fin_go;
    logic [lfu_ohc_pkg::CNT_W-1:0]       cap;
    logic                                n_evict;
    logic [lfu_ohc_pkg::ENTRIES-1:0]     n_free;
    logic [lfu_ohc_pkg::IDX_W-1:0]       n_slot;
    logic [lfu_ohc_pkg::COUNT_W-1:0]     n_count;
    logic                                in_acc;

    lfu_ohc_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (wr_entry),
        .i_raddr (r_idx[lfu_ohc_pkg::IDX_W-1:0]),
        .o_rdata (rd_entry)
    );

    lfu_ohc_cmp u_cmp (
        .i_entry (rd_entry),
        .i_best  (r_best),
        .i_key   (r_key),
        .o_res   (cmp_res)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign fin_go     = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        cap = (r_max_open > lfu_ohc_pkg::CAP_W'(lfu_ohc_pkg::ENTRIES))
            ? lfu_ohc_pkg::CNT_W'(lfu_ohc_pkg::ENTRIES)
            : lfu_ohc_pkg::CNT_W'(r_max_open);
        n_evict = !r_found && r_have_best && (r_used >= cap);
        n_free  = ~r_valid_bits;
        if (n_evict) begin
            n_free[r_best_idx] = 1'b1;
        end
        n_slot = '0;
        for (int i = lfu_ohc_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (n_free[i]) begin
                n_slot = lfu_ohc_pkg::IDX_W'(i);
            end
        end
        n_count = (r_found_cnt == lfu_ohc_pkg::COUNT_MAX)
                ? r_found_cnt : r_found_cnt + lfu_ohc_pkg::COUNT_W'(1);
        mem_we         = fin_go && !r_bypass && (r_found || (|n_free));
        mem_waddr      = r_found ? r_found_idx : n_slot;
        wr_entry.key   = r_key;
        wr_entry.count = r_found ? n_count : lfu_ohc_pkg::COUNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_max_open   <= '0;
            r_valid_bits <= '0;
            r_pvld       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_open <= i_cfg_wdata;
            end
            if (r_out_valid && i_out_ready && !fin_go) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_idx       <= '0;
                    r_pvld      <= 1'b0;
                    r_used      <= '0;
                    r_found     <= 1'b0;
                    r_have_best <= 1'b0;
                    if (in_acc) begin
                        r_key    <= i_key;
                        r_bypass <= (r_max_open == '0);
                        r_state  <= (r_max_open == '0) ? S_FIN : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pvld <= (r_idx < lfu_ohc_pkg::CNT_W'(lfu_ohc_pkg::ENTRIES));
                    r_pidx <= r_idx[lfu_ohc_pkg::IDX_W-1:0];
                    if (r_idx < lfu_ohc_pkg::CNT_W'(lfu_ohc_pkg::ENTRIES)) begin
                        r_idx <= r_idx + lfu_ohc_pkg::CNT_W'(1);
                    end
                    if (r_pvld && r_valid_bits[r_pidx]) begin
                        r_used <= r_used + lfu_ohc_pkg::CNT_W'(1);
                        if (cmp_res.match) begin
                            r_found     <= 1'b1;
                            r_found_idx <= r_pidx;
                            r_found_cnt <= rd_entry.count;
                        end
                        if (!r_have_best || cmp_res.better) begin
                            r_have_best <= 1'b1;
                            r_best      <= rd_entry;
                            r_best_idx  <= r_pidx;
                        end
                    end
                    if (r_pvld && (r_idx == lfu_ohc_pkg::CNT_W'(lfu_ohc_pkg::ENTRIES))) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_out_valid   <= 1'b1;
                        r_out_bypass  <= r_bypass;
                        r_out_hit     <= !r_bypass && r_found;
                        r_out_evicted <= !r_bypass && n_evict;
                        r_out_evicted_key <= (!r_bypass && n_evict) ? r_best.key : '0;
                        if (r_bypass) begin
                            r_out_use_count <= '0;
                        end else begin
                            r_out_use_count <= wr_entry.count;
                        end
                        if (!r_bypass && !r_found) begin
                            r_valid_bits <= ~n_free | (lfu_ohc_pkg::ENTRIES'(1) << n_slot);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_bypass      = r_out_bypass;
    assign o_hit         = r_out_hit;
    assign o_evicted     = r_out_evicted;
    assign o_evicted_key = r_out_evicted_key;
    assign o_use_count   = r_out_use_count;

    `LFU_ASSERT_NEXT(a_scan_start, in_acc && (r_max_open != '0), r_state == S_SCAN,
                     "enabled item did not start a scan")
    `LFU_ASSERT_NOW(a_evict_excl, r_out_valid && r_out_evicted,
                    !r_out_hit && !r_out_bypass, "eviction reported together with hit or bypass")
    `LFU_ASSERT_NOW(a_hit_count, r_out_valid && r_out_hit, r_out_use_count != '0,
                    "hit reported with zero use count")
    `LFU_ASSERT_NEXT(a_insert_valid, mem_we && !r_found, r_valid_bits[$past(n_slot)],
                     "inserted entry not marked valid")

endmodule

FILE: bench/lfu_ohc_checker.sv
// Checker for the handle cache: predicts each access result and compares it with the block's output.
module lfu_ohc_checker
    import lfu_ohc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CAP_W-1:0]   i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [KEY_W-1:0]   i_key,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_bypass,
    input  logic               i_hit,
    input  logic               i_evicted,
    input  logic [KEY_W-1:0]   i_evicted_key,
    input  logic [COUNT_W-1:0] i_use_count,
    output int                 o_mismatches,
    output int                 o_pending,
    output int                 o_hits,
    output int                 o_evictions,
    output int                 o_bypasses
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               bypass;
        logic               hit;
        logic               evicted;
        logic [KEY_W-1:0]   evicted_key;
        logic [COUNT_W-1:0] use_count;
    } t_access_result;

    logic               slot_valid [ENTRIES];
    logic [KEY_W-1:0]   slot_key   [ENTRIES];
    logic [COUNT_W-1:0] slot_count [ENTRIES];
    logic [CAP_W-1:0]   capacity;
    t_access_result     awaited_results [$];
    t_access_result     oldest;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_hits       = 0;
        o_evictions  = 0;
        o_bypasses   = 0;
        capacity     = '0;
        foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    end

    function automatic t_access_result predict_access(input logic [KEY_W-1:0] key);
        t_access_result res;
        int limit;
        int used;
        int found;
        int victim;
        int free_slot;
        res = '0;
        if (capacity == 0) begin
            res.bypass = 1'b1;
            return res;
        end
        limit     = (capacity > ENTRIES) ? ENTRIES : int'(capacity);
        used      = 0;
        found     = -1;
        victim    = -1;
        free_slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i]) begin
                used++;
                if (slot_key[i] == key) found = i;
            end
        end
        if (found >= 0) begin
            res.hit = 1'b1;
            if (slot_count[found] != COUNT_MAX) slot_count[found]++;
            res.use_count = slot_count[found];
            return res;
        end
        if (used >= limit) begin
            // The victim is the lowest count; a tie goes to the lowest key.
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot_valid[i] && (victim < 0 || slot_count[i] < slot_count[victim] ||
                    (slot_count[i] == slot_count[victim] && slot_key[i] < slot_key[victim])))
                    victim = i;
            end
            if (victim >= 0) begin
                res.evicted       = 1'b1;
                res.evicted_key   = slot_key[victim];
                slot_valid[victim] = 1'b0;
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!slot_valid[i]) free_slot = i;
        end
        if (free_slot >= 0) begin
            slot_valid[free_slot] = 1'b1;
            slot_key[free_slot]   = key;
            slot_count[free_slot] = 1;
        end
        res.use_count = 1;
        return res;
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
            o_mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
            capacity = '0;
            awaited_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $display({"%0t ns: result expected none, got bypass %b hit %b ",
                              "evicted %b key %h count %h"},
                             $time, i_bypass, i_hit, i_evicted, i_evicted_key, i_use_count);
                    o_mismatches++;
                end else begin
                    oldest = awaited_results.pop_front();
                    compare_field("bypass", 32'(oldest.bypass), 32'(i_bypass));
                    compare_field("hit", 32'(oldest.hit), 32'(i_hit));
                    compare_field("evicted", 32'(oldest.evicted), 32'(i_evicted));
                    compare_field("evicted_key", oldest.evicted_key, i_evicted_key);
                    compare_field("use_count", oldest.use_count, i_use_count);
                    if (oldest.hit) o_hits++;
                    if (oldest.evicted) o_evictions++;
                    if (oldest.bypass) o_bypasses++;
                end
            end
            if (i_in_valid && i_in_ready) awaited_results.push_back(predict_access(i_key));
            if (i_cfg_we) capacity = i_cfg_wdata;
        end
        o_pending = awaited_results.size();
    end

endmodule

FILE: bench/tb.sv
// Testbench top for the handle cache: clock, reset, access stimulus, capacity phases and verdict.
module tb;
    import lfu_ohc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_SLOW} t_ready_mode;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CAP_W-1:0]     i_cfg_wdata = '0;
    logic                 i_in_valid  = 1'b0;
    logic [KEY_W-1:0]     i_key       = '0;
    logic                 i_out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_bypass;
    logic                 o_hit;
    logic                 o_evicted;
    logic [KEY_W-1:0]     o_evicted_key;
    logic [COUNT_W-1:0]   o_use_count;

    int mismatches;
    int pending;
    int hits;
    int evictions;
    int bypasses;
    int accesses_sent   = 0;
    int capacity_writes = 0;
    int burst_left      = 0;

    t_ready_mode ready_mode = READY_ALWAYS;
    int          mode_left  = 0;
    int          hold_left  = 0;

    logic [KEY_W-1:0] key_pool [16];

    lfu_open_handle_cache_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_key         (i_key),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_bypass      (o_bypass),
        .o_hit         (o_hit),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key),
        .o_use_count   (o_use_count)
    );

    lfu_ohc_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_key         (i_key),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_bypass      (o_bypass),
        .i_hit         (o_hit),
        .i_evicted     (o_evicted),
        .i_evicted_key (o_evicted_key),
        .i_use_count   (o_use_count),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_hits        (hits),
        .o_evictions   (evictions),
        .o_bypasses    (bypasses)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 2));
            mode_left  = $urandom_range(50, 400);
        end
        mode_left--;
        case (ready_mode)
            READY_ALWAYS: i_out_ready = 1'b1;
            READY_COIN:   i_out_ready = ($urandom_range(0, 3) != 0);
            default: begin
                if (hold_left == 0) begin
                    i_out_ready = ~i_out_ready;
                    hold_left   = $urandom_range(1, 24);
                end
                hold_left--;
            end
        endcase
    end

    task automatic send_key(input logic [KEY_W-1:0] key);
        i_key      = key;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        accesses_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] value);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        capacity_writes++;
    endtask

    initial begin
        int               pick;
        int               pool_size;
        logic [KEY_W-1:0] key;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Capacity is zero out of reset, so these bypass the table.
        send_key('0);
        send_key('1);

        // Capacity above the table size acts as the full table.
        set_capacity(4'd15);
        send_key('0);
        send_key('1);
        send_key(32'd5);
        send_key(32'd5);
        send_key(32'd7);
        send_key(32'd3);
        send_key(32'd9);
        send_key(32'd11);
        send_key(32'd13);
        send_key(32'd20);
        send_key('1);

        // Entries survive while caching is off and are used again afterwards.
        set_capacity(4'd0);
        send_key(32'd5);
        set_capacity(4'd8);
        send_key(32'd5);

        // Lowering the capacity on a full table evicts one entry per miss.
        set_capacity(4'd2);
        send_key(32'd100);
        send_key(32'd101);
        send_key(32'd102);
        set_capacity(4'd1);
        send_key(32'd102);
        send_key(32'hAAAA_AAAA);
        send_key(32'h5555_5555);

        foreach (key_pool[i]) key_pool[i] = $urandom();
        while (accesses_sent < 1620) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)      set_capacity(4'd0);
            else if (pick == 1) set_capacity(4'($urandom_range(9, 15)));
            else                set_capacity(4'($urandom_range(1, 8)));
            pool_size = $urandom_range(2, 12);
            foreach (key_pool[i]) begin
                if ($urandom_range(0, 1) == 0)
                    key_pool[i] = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom_range(0, 15))
                                                              : KEY_W'($urandom());
            end
            repeat ($urandom_range(20, 120)) begin
                pick = $urandom_range(0, 99);
                if (pick < 50)      key = key_pool[$urandom_range(0, 1)];
                else if (pick < 92) key = key_pool[$urandom_range(0, pool_size - 1)];
                else if (pick < 96) key = $urandom();
                else                key = ($urandom_range(0, 1) == 0) ? '0 : '1;
                send_key(key);
            end
        end

        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("Sent %0d accesses across %0d capacity settings.", accesses_sent,
                 capacity_writes);
        $display("Saw %0d hits, %0d evictions and %0d bypassed accesses.", hits, evictions,
                 bypasses);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("Run timed out with %0d results outstanding.", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: lfu_open_handle_cache_top.f
+incdir+rtl
rtl/lfu_ohc_pkg.sv
rtl/lfu_ohc_mem.sv
rtl/lfu_ohc_cmp.sv
rtl/lfu_open_handle_cache_top.sv
bench/lfu_ohc_checker.sv
bench/tb.sv
